@@ src/dct_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNA codon translator package
// Types, base codes, amino acid codes and the standard codon table shared by
// the channel interfaces and the translator.
// ----------------------------------------------------------------------------
package dct_pkg;

    // Field widths of the two channels.
    localparam int unsigned CharW  = 8;
    localparam int unsigned AminoW = 5;

    // Base code: A, C, G, T as 0 to 3, anything else as a non-base.
    typedef logic [2:0] t_base;

    localparam t_base BASE_A    = 3'd0;
    localparam t_base BASE_C    = 3'd1;
    localparam t_base BASE_G    = 3'd2;
    localparam t_base BASE_T    = 3'd3;
    localparam t_base BASE_NONE = 3'd4;

    typedef logic [AminoW-1:0] t_amino;

    localparam t_amino AMINO_MET  = 5'd12;
    localparam t_amino STOP_OCHRE = 5'd20;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_TRANS  = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    typedef struct packed {
        t_amino amino_code;
        logic   is_stop;
    } t_result;

    // Indexed by first*16 + second*4 + third with A=0, C=1, G=2, T=3.
    localparam t_amino CODON_TABLE [64] = '{
        5'd11, 5'd2,  5'd11, 5'd2,  5'd16, 5'd16, 5'd16, 5'd16,
        5'd1,  5'd15, 5'd1,  5'd15, 5'd9,  5'd9,  5'd12, 5'd9,
        5'd5,  5'd8,  5'd5,  5'd8,  5'd14, 5'd14, 5'd14, 5'd14,
        5'd1,  5'd1,  5'd1,  5'd1,  5'd10, 5'd10, 5'd10, 5'd10,
        5'd6,  5'd3,  5'd6,  5'd3,  5'd0,  5'd0,  5'd0,  5'd0,
        5'd7,  5'd7,  5'd7,  5'd7,  5'd19, 5'd19, 5'd19, 5'd19,
        5'd20, 5'd18, 5'd21, 5'd18, 5'd15, 5'd15, 5'd15, 5'd15,
        5'd22, 5'd4,  5'd17, 5'd4,  5'd10, 5'd13, 5'd10, 5'd13
    };

    // Only upper-case A, C, G and T are bases.
    function automatic t_base base_code(input logic [CharW-1:0] c);
        t_base b;
        unique case (c)
            8'h41:   b = BASE_A;
            8'h43:   b = BASE_C;
            8'h47:   b = BASE_G;
            8'h54:   b = BASE_T;
            default: b = BASE_NONE;
        endcase
        return b;
    endfunction

endpackage

@@ src/dct_stream_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNA codon translator channels
// Valid/ready channels for sequence characters in and amino acid codes out.
// ----------------------------------------------------------------------------
interface dct_base_if;
    logic                         valid;
    logic                         ready;
    logic [dct_pkg::CharW-1:0]    base_char;
    logic                         restart;

    modport source (output valid, output base_char, output restart, input ready);
    modport sink   (input valid, input base_char, input restart, output ready);
endinterface

interface dct_amino_if;
    logic                  valid;
    logic                  ready;
    dct_pkg::t_amino       amino_code;
    logic                  is_stop;

    modport source (output valid, output amino_code, output is_stop, input ready);
    modport sink   (input valid, input amino_code, input is_stop, output ready);
endinterface

@@ src/dna_codon_translator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNA codon translator
// Finds the ATG start codon in a stream of sequence characters, then
// translates each following codon into an amino acid code until a stop.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                   Items
//  i_base    in         base_char[7:0], restart   one sequence character
//  o_amino   out        amino_code[4:0], is_stop  zero or one per character
//
// Every input item is handled in the cycle in which it is accepted: the phase,
// the two-entry base window and the codon position are updated at that edge,
// and any result is loaded into the output register, so one item per cycle is
// sustained while o_amino.ready is high. The output register is the only
// buffer; i_base.ready is low only while it holds a result not yet taken.
// Reset is synchronous and active low; it clears the phase to searching, the
// window to non-bases and the output register to empty. A restart bit on an
// item resets phase and window likewise before that item's character is used.

module dna_codon_translator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    dct_base_if.sink            i_base,
    dct_amino_if.source         o_amino
);

    // Architectural state.
    dct_pkg::t_phase  r_phase,  n_phase;
    dct_pkg::t_base   r_win0,   n_win0;
    dct_pkg::t_base   r_win1,   n_win1;
    logic [1:0]       r_pos,    n_pos;

    // Output register.
    logic             r_out_valid, n_out_valid;
    dct_pkg::t_result r_out,       n_out;

    // State as seen by the current item, after an optional restart.
    dct_pkg::t_phase  e_phase;
    dct_pkg::t_base   e_win0;
    dct_pkg::t_base   e_win1;
    logic [1:0]       e_pos;

    dct_pkg::t_base   w_base;
    logic             w_in_acc;
    logic             w_hit;
    logic             w_codon_ok;
    dct_pkg::t_amino  w_code;
    logic             w_code_stop;

    // A new item is taken whenever the output register is empty or is being
    // emptied in this cycle.
    assign i_base.ready = !r_out_valid || o_amino.ready;
    assign w_in_acc     = i_base.valid && i_base.ready;
    assign w_base       = dct_pkg::base_code(i_base.base_char);

    assign e_phase = i_base.restart ? dct_pkg::PH_SEARCH : r_phase;
    assign e_win0  = i_base.restart ? dct_pkg::BASE_NONE : r_win0;
    assign e_win1  = i_base.restart ? dct_pkg::BASE_NONE : r_win1;
    assign e_pos   = i_base.restart ? 2'd0 : r_pos;

    // ATG ends the search: A and T already in the window, G arriving now.
    assign w_hit = (e_win0 == dct_pkg::BASE_A) && (e_win1 == dct_pkg::BASE_T) &&
                   (w_base == dct_pkg::BASE_G);

    // A codon with any non-base in it is dropped silently.
    assign w_codon_ok  = !e_win0[2] && !e_win1[2] && !w_base[2];
    assign w_code      = dct_pkg::CODON_TABLE[{e_win0[1:0], e_win1[1:0], w_base[1:0]}];
    assign w_code_stop = (w_code >= dct_pkg::STOP_OCHRE);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (w_in_acc) begin
            unique case (e_phase)
                dct_pkg::PH_SEARCH: begin
                    n_phase = w_hit ? dct_pkg::PH_TRANS : dct_pkg::PH_SEARCH;
                end
                dct_pkg::PH_TRANS: begin
                    if ((e_pos == 2'd2) && w_codon_ok && w_code_stop) begin
                        n_phase = dct_pkg::PH_DONE;
                    end else begin
                        n_phase = dct_pkg::PH_TRANS;
                    end
                end
                default: begin
                    n_phase = e_phase;
                end
            endcase
        end
    end

    // Window, codon position and result.
    always_comb begin
        n_win0      = r_win0;
        n_win1      = r_win1;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !o_amino.ready;
        n_out       = r_out;
        if (w_in_acc) begin
            n_win0 = e_win0;
            n_win1 = e_win1;
            n_pos  = e_pos;
            unique case (e_phase)
                dct_pkg::PH_SEARCH: begin
                    if (w_hit) begin
                        // Met opens the protein; codons start on the next byte.
                        n_win0      = dct_pkg::BASE_NONE;
                        n_win1      = dct_pkg::BASE_NONE;
                        n_pos       = 2'd0;
                        n_out_valid = 1'b1;
                        n_out       = '{amino_code: dct_pkg::AMINO_MET, is_stop: 1'b0};
                    end else begin
                        n_win0 = e_win1;
                        n_win1 = w_base;
                    end
                end
                dct_pkg::PH_TRANS: begin
                    if (e_pos == 2'd2) begin
                        n_pos = 2'd0;
                        if (w_codon_ok) begin
                            n_out_valid = 1'b1;
                            n_out       = '{amino_code: w_code, is_stop: w_code_stop};
                        end
                    end else begin
                        if (e_pos[0]) begin
                            n_win1 = w_base;
                        end else begin
                            n_win0 = w_base;
                        end
                        n_pos = e_pos + 2'd1;
                    end
                end
                default: begin
                    // After a stop every character is ignored.
                    n_pos = e_pos;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= dct_pkg::PH_SEARCH;
            r_win0      <= dct_pkg::BASE_NONE;
            r_win1      <= dct_pkg::BASE_NONE;
            r_pos       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_win0      <= n_win0;
            r_win1      <= n_win1;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_amino.valid      = r_out_valid;
    assign o_amino.amino_code = r_out.amino_code;
    assign o_amino.is_stop    = r_out.is_stop;

    // The stop flag is only ever set for one of the three stop codes.
    a_stop_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.is_stop) |-> (r_out.amino_code >= dct_pkg::STOP_OCHRE))
        else $error("stop flag on a non-stop amino code");

    // Codon position only counts while translating.
    a_pos_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != dct_pkg::PH_TRANS) |-> (r_pos == 2'd0))
        else $error("codon position non-zero outside translation");

    // Once done, a character without restart produces nothing.
    a_done_silent : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == dct_pkg::PH_DONE && w_in_acc && !i_base.restart && o_amino.ready)
        |=> !r_out_valid)
        else $error("result produced after a stop");

    // Met from the start search never carries the stop flag.
    a_hit_met : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && e_phase == dct_pkg::PH_SEARCH && w_hit)
        |=> (r_out_valid && r_out.amino_code == dct_pkg::AMINO_MET && !r_out.is_stop
             && r_phase == dct_pkg::PH_TRANS))
        else $error("start codon did not produce Met");

endmodule
